@@ rtl/core/edfs_pkg.sv @@
// Shared types, constants and helpers for the EDF periodic task scheduler.
// Depends on nothing; edfs_rem_div and the scheduler import it.
package edfs_pkg;

  localparam int MAX_TASK_SLOTS = 8;
  localparam int QUEUE_DEPTH    = 16;
  localparam int TASK_AW        = $clog2(MAX_TASK_SLOTS);
  localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 4;

  // input kinds carried in in_tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // configuration register indexes
  localparam logic REG_HYPERPERIOD = 1'b0;
  localparam logic REG_TASK_COUNT  = 1'b1;

  // one task table row
  typedef struct packed {
    logic [15:0] period;
    logic [15:0] deadline;
    logic [15:0] exec_t;
    logic [15:0] phase;   // current time modulo period
    logic [15:0] jobs;    // job counter
  } task_word_t;

  // one ready-queue entry
  typedef struct packed {
    logic [3:0]  task_id;
    logic [15:0] job;
    logic [16:0] deadline;
    logic [15:0] remaining;
  } q_word_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] rem;
  } div_rsp_t;

  // scheduling order: earliest deadline, lowest task id, lowest job number
  function automatic logic goes_before(input q_word_t a, input q_word_t b);
    if (a.deadline != b.deadline) return a.deadline < b.deadline;
    if (a.task_id != b.task_id) return a.task_id < b.task_id;
    return a.job < b.job;
  endfunction

endpackage

@@ rtl/core/edfs_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module edfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/edfs_rem_div.sv @@
// Bit-serial restoring remainder unit: one quotient bit per cycle over the 16-bit dividend.
// Depends on edfs_pkg for the request and response structs.
module edfs_rem_div (
  input  logic                clk,
  input  logic                rst_n,
  input  edfs_pkg::div_req_t  req,
  output edfs_pkg::div_rsp_t  rsp
);
  import edfs_pkg::*;

  logic [15:0] rem_r;
  logic [15:0] shreg_r;
  logic [15:0] divisor_r;
  logic [3:0]  step_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] trial;
  logic [16:0] diff;

  assign trial = {rem_r, shreg_r[15]};
  assign diff  = trial - {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r    <= 1'b1;
        step_r    <= '0;
        rem_r     <= '0;
        shreg_r   <= req.dividend;
        divisor_r <= req.divisor;
      end else if (busy_r) begin
        // keep the trial difference when it does not go negative
        rem_r   <= (trial >= {1'b0, divisor_r}) ? diff[15:0] : trial[15:0];
        shreg_r <= {shreg_r[14:0], 1'b0};
        step_r  <= step_r + 4'd1;
        if (step_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

@@ rtl/core/edf_periodic_task_scheduler.sv @@
// Preemptive earliest-deadline-first scheduler over periodic tasks.
// A tick walks the 8-row task table, takes a read turnaround, walks the 16-entry queue,
//   makes the update and loads the output (waiting on out_tready), then raises out_tvalid;
//   past the hyperperiod or after a halt it goes straight to the output load. No new beat
//   is taken until then; a task write holds in_tready low (read, divider steps, write back).
// Reset (rst_n synchronous, active low): time 0, not halted, queue empty, job
//   counters zero, hyperperiod 1, task count 1; no clearing pass is needed.
module edf_periodic_task_scheduler (
  input  logic                             clk,
  input  logic                             rst_n,
  // input: task_index[2:0], period[18:3], relative_deadline[34:19], exec_time[50:35]
  input  logic [edfs_pkg::IN_DATA_W-1:0]   in_tdata,
  // input kind: command[0]
  input  logic                             in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // result: slot_time[15:0], run_task[19:16], run_job[35:20]
  output logic [edfs_pkg::OUT_DATA_W-1:0]  out_tdata,
  // flags: idle[0], job_done[1], deadline_missed[2], finished[3]
  output logic [edfs_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [15:0]                      cfg_data
);
  import edfs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WR_RD, ST_WR_DIV, ST_REL, ST_QRD, ST_SEL, ST_FIN, ST_OUT
  } state_t;

  state_t               state_r;
  logic [TASK_AW-1:0]   cnt_r;
  logic [QUEUE_AW-1:0]  qcnt_r;
  logic [15:0]          time_r;
  logic                 halted_r;
  logic [15:0]          hyper_r;
  logic [3:0]           tcount_r;
  logic [MAX_TASK_SLOTS-1:0] tvld_r;
  logic [QUEUE_DEPTH-1:0]    qvld_r;
  logic [TASK_AW-1:0]   wr_idx_r;
  logic [15:0]          wr_period_r;
  logic [15:0]          wr_dl_r;
  logic [15:0]          wr_exec_r;
  logic [15:0]          wr_jc_r;
  logic                 found_r;
  q_word_t              best_r;
  logic [QUEUE_AW-1:0]  best_idx_r;
  logic [OUT_DATA_W-1:0] res_data_r;
  logic [OUT_USER_W-1:0] res_user_r;
  logic                 out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_USER_W-1:0] out_tuser_r;

  // task table and ready queue memories
  logic                 t_we;
  logic [TASK_AW-1:0]   t_waddr, t_raddr;
  task_word_t           t_wdata, t_rd;
  logic [$bits(task_word_t)-1:0] t_rdata;
  logic                 q_we;
  logic [QUEUE_AW-1:0]  q_waddr, q_raddr;
  q_word_t              q_wdata, q_rd;
  logic [$bits(q_word_t)-1:0] q_rdata;

  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic                 in_acc;
  logic [3:0]           n_used;
  logic [15:0]          jc_cur, jc_new;
  logic [16:0]          phase_inc;
  logic [15:0]          phase_nxt;
  logic                 rel;
  logic                 free_any;
  logic [QUEUE_AW-1:0]  free_idx;
  logic                 miss;
  logic [15:0]          rem_dec;
  logic                 out_free;

  edfs_ram #(.WIDTH($bits(task_word_t)), .DEPTH(MAX_TASK_SLOTS)) u_task_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  edfs_ram #(.WIDTH($bits(q_word_t)), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  edfs_rem_div u_rem_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp)
  );

  assign t_rd = t_rdata;
  assign q_rd = q_rdata;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;

  // clamp the task count to the table size
  assign n_used = (tcount_r > 4'(MAX_TASK_SLOTS)) ? 4'(MAX_TASK_SLOTS) : tcount_r;

  // release decision for the task row being walked
  assign jc_cur    = tvld_r[cnt_r] ? t_rd.jobs : 16'd0;
  assign rel       = ({1'b0, cnt_r} < n_used) && (t_rd.period != 16'd0) &&
                     (t_rd.phase == 16'd0);
  assign jc_new    = rel ? jc_cur + 16'd1 : jc_cur;
  // advance the phase for the next tick; a halted block never reads it again
  assign phase_inc = {1'b0, t_rd.phase} + 17'd1;
  assign phase_nxt = (phase_inc == {1'b0, t_rd.period}) ? 16'd0 : phase_inc[15:0];

  // lowest free queue entry
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int q = QUEUE_DEPTH - 1; q >= 0; q--) begin
      if (!qvld_r[q]) begin
        free_any = 1'b1;
        free_idx = QUEUE_AW'(q);
      end
    end
  end

  // the earliest job is a miss whenever any job has passed its deadline
  assign miss    = found_r && ({1'b0, time_r} >= best_r.deadline);
  assign rem_dec = best_r.remaining - 16'd1;

  // task table ports
  always_comb begin
    t_raddr = '0;
    if (state_r == ST_IDLE && in_tuser == CMD_WRITE) begin
      t_raddr = in_tdata[TASK_AW-1:0];
    end else if (state_r == ST_REL) begin
      t_raddr = cnt_r + TASK_AW'(1);
    end
    t_we    = 1'b0;
    t_waddr = wr_idx_r;
    t_wdata = '{period: wr_period_r, deadline: wr_dl_r, exec_t: wr_exec_r,
                phase: div_rsp.rem, jobs: wr_jc_r};
    if (state_r == ST_REL) begin
      t_we    = 1'b1;
      t_waddr = cnt_r;
      t_wdata = '{period: t_rd.period, deadline: t_rd.deadline, exec_t: t_rd.exec_t,
                  phase: phase_nxt, jobs: jc_new};
    end else if (state_r == ST_WR_DIV && div_rsp.done) begin
      t_we = 1'b1;
    end
  end

  // ready queue ports
  always_comb begin
    q_raddr = (state_r == ST_SEL) ? qcnt_r + QUEUE_AW'(1) : '0;
    q_we    = 1'b0;
    q_waddr = free_idx;
    q_wdata = '{task_id: 4'({1'b0, cnt_r} + 4'd1), job: jc_new,
                deadline: {1'b0, time_r} + {1'b0, t_rd.deadline},
                remaining: t_rd.exec_t};
    if (state_r == ST_REL) begin
      q_we = rel && (t_rd.exec_t != 16'd0) && free_any;
    end else if (state_r == ST_FIN) begin
      q_we    = found_r && !miss;
      q_waddr = best_idx_r;
      q_wdata = best_r;
      q_wdata.remaining = rem_dec;
    end
  end

  assign div_req.start    = (state_r == ST_WR_RD);
  assign div_req.dividend = time_r;
  assign div_req.divisor  = wr_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      time_r       <= '0;
      halted_r     <= 1'b0;
      hyper_r      <= 16'd1;
      tcount_r     <= 4'd1;
      tvld_r       <= '0;
      qvld_r       <= '0;
      out_tvalid_r <= 1'b0;
      found_r      <= 1'b0;
      cnt_r        <= '0;
      qcnt_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HYPERPERIOD) hyper_r <= cfg_data;
        else if (cfg_index == REG_TASK_COUNT) tcount_r <= cfg_data[3:0];
      end
      // drop the beat once taken, unless a new one is loaded below
      if (out_tvalid_r && out_tready && state_r != ST_OUT) out_tvalid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_tuser == CMD_WRITE) begin
              wr_idx_r    <= in_tdata[TASK_AW-1:0];
              wr_period_r <= in_tdata[18:3];
              wr_dl_r     <= in_tdata[34:19];
              wr_exec_r   <= in_tdata[50:35];
              state_r     <= ST_WR_RD;
            end else if (halted_r || time_r >= hyper_r) begin
              res_data_r <= {24'd0, time_r};
              res_user_r <= 4'b1000;
              state_r    <= ST_OUT;
            end else begin
              cnt_r   <= '0;
              state_r <= ST_REL;
            end
          end
        end
        ST_WR_RD: begin
          // hold the job counter across the rewrite
          wr_jc_r <= tvld_r[wr_idx_r] ? t_rd.jobs : 16'd0;
          state_r <= ST_WR_DIV;
        end
        ST_WR_DIV: begin
          if (div_rsp.done) begin
            tvld_r[wr_idx_r] <= 1'b1;
            state_r          <= ST_IDLE;
          end
        end
        ST_REL: begin
          tvld_r[cnt_r] <= 1'b1;
          if (q_we) qvld_r[free_idx] <= 1'b1;
          cnt_r <= cnt_r + TASK_AW'(1);
          if (cnt_r == TASK_AW'(MAX_TASK_SLOTS - 1)) state_r <= ST_QRD;
        end
        ST_QRD: begin
          // read turnaround after the last queue write
          qcnt_r  <= '0;
          found_r <= 1'b0;
          state_r <= ST_SEL;
        end
        ST_SEL: begin
          if (qvld_r[qcnt_r] && (!found_r || goes_before(q_rd, best_r))) begin
            best_r     <= q_rd;
            best_idx_r <= qcnt_r;
            found_r    <= 1'b1;
          end
          qcnt_r <= qcnt_r + QUEUE_AW'(1);
          if (qcnt_r == QUEUE_AW'(QUEUE_DEPTH - 1)) state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (miss) begin
            halted_r   <= 1'b1;
            res_data_r <= {4'd0, best_r.job, best_r.task_id, time_r};
            res_user_r <= 4'b0100;
          end else begin
            time_r <= time_r + 16'd1;
            if (!found_r) begin
              res_data_r <= {24'd0, time_r};
              res_user_r <= 4'b0001;
            end else begin
              res_data_r <= {4'd0, best_r.job, best_r.task_id, time_r};
              if (rem_dec == 16'd0) begin
                qvld_r[best_idx_r] <= 1'b0;
                res_user_r         <= 4'b0010;
              end else begin
                res_user_r <= 4'b0000;
              end
            end
          end
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= res_data_r;
            out_tuser_r  <= res_user_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r) else $error("halt flag cleared");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> $onehot0(out_tuser_r)) else $error("result flags overlap");

  a_time_moves_at_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_FIN |=> time_r == $past(time_r)) else $error("time moved off update");

  a_div_done_in_write: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_WR_DIV) else $error("stray divider result");

endmodule
